// File: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

	localparam int CFG_BITS    = 13;
	localparam int OFFSET_BITS = 24;
	localparam int COLOR_BITS  = 32;
	localparam int APB_DATA    = 32;
	localparam int APB_ADDR    = 3;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd768;

	typedef enum logic [0:0] {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] width;
		logic [CFG_BITS-1:0] height;
	} lr_cfg_t;

endpackage

`default_nettype wire

// File: rtl/lr_if.sv
// ----------------------------------------------------------------------------
// lr_cmd_if / lr_pix_if
// Valid/ready channels for line commands and generated pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lr_cmd_if
	import lr_pkg::*;
	#(parameter int COORD_BITS = 13);

	logic                         valid;
	logic                         ready;
	op_t                          op;
	logic signed [COORD_BITS-1:0] x_start;
	logic signed [COORD_BITS-1:0] y_start;
	logic signed [COORD_BITS-1:0] x_end;
	logic signed [COORD_BITS-1:0] y_end;
	logic [COLOR_BITS-1:0]        color;

	modport source (output valid, op, x_start, y_start, x_end, y_end, color, input ready);
	modport sink   (input valid, op, x_start, y_start, x_end, y_end, color, output ready);

endinterface

interface lr_pix_if
	import lr_pkg::*;
	#(parameter int COORD_BITS = 13);

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pix_x;
	logic signed [COORD_BITS-1:0] pix_y;
	logic [OFFSET_BITS-1:0]       pixel_offset;
	logic [COLOR_BITS-1:0]        pix_color;
	logic                         in_bounds;
	logic                         last;

	modport source (output valid, pix_x, pix_y, pixel_offset, pix_color, in_bounds, last,
		input ready);
	modport sink   (input valid, pix_x, pix_y, pixel_offset, pix_color, in_bounds, last,
		output ready);

endinterface

`default_nettype wire

// File: rtl/lr_cfg_regs.sv
// ----------------------------------------------------------------------------
// lr_cfg_regs
// APB register block holding the screen width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_cfg_regs
	import lr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_ADDR-1:0] paddr,
	input  wire logic [APB_DATA-1:0] pwdata,
	output      logic [APB_DATA-1:0] prdata,
	output      logic                pready,
	output      lr_cfg_t             cfg
);

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	reg_idx_t            idx;
	logic                wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = APB_DATA'(width_q);
			REG_HEIGHT: prdata = APB_DATA'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.width  = width_q;
	assign cfg.height = height_q;

endmodule

`default_nettype wire

// File: rtl/line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Bresenham line generator with screen clipping and framebuffer offset.
// ----------------------------------------------------------------------------
// A start command loads a line and produces nothing; each step command then
// returns one pixel, the last one flagged, until the line ends. Every command
// passes an input register and then the logic (error update, bounds test and
// one y*width multiply); a step's pixel is registered into the output register
// and presented there until it transfers. One command is taken per cycle, but a
// pixel held in the output register stalls a further step behind it, while
// starts and idle steps still pass.
`default_nettype none

module line_rasterizer_core
	import lr_pkg::*;
#(
	parameter int COORD_BITS = 13
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	lr_cmd_if.sink                   cmd,
	lr_pix_if.source                 pix,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_ADDR-1:0] paddr,
	input  wire logic [APB_DATA-1:0] pwdata,
	output      logic [APB_DATA-1:0] prdata,
	output      logic                pready
);

	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int CMP_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
	localparam int PROD_BITS  = ((COORD_BITS + CFG_BITS > OFFSET_BITS) ?
		COORD_BITS + CFG_BITS : OFFSET_BITS) + 1;

	lr_cfg_t cfg;

	lr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic                         valid_s1;
	op_t                          op_s1;
	logic signed [COORD_BITS-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COLOR_BITS-1:0]        color_s1;

	// line state
	logic                         busy_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic [DELTA_BITS-1:0]        adx_q, ady_q;
	logic                         step_x_neg_q, step_y_neg_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic [COLOR_BITS-1:0]        line_color_q;

	// output register
	logic                         valid_s2;
	logic signed [COORD_BITS-1:0] pix_x_s2, pix_y_s2;
	logic [OFFSET_BITS-1:0]       offset_s2;
	logic [COLOR_BITS-1:0]        color_s2;
	logic                         inb_s2, last_s2;

	logic                         has_result, out_free, adv;
	logic signed [DELTA_BITS-1:0] dx, dy;
	logic [DELTA_BITS-1:0]        adx_new, ady_new;
	logic signed [ERR_BITS-1:0]   err_init, adx_e, ady_e, err_next;
	logic                         inb, fin, move_x, move_y;
	logic [PROD_BITS-1:0]         off_full;
	logic [OFFSET_BITS-1:0]       off;

	assign has_result = valid_s1 && (op_s1 == OP_STEP) && busy_q;
	assign out_free   = !valid_s2 || pix.ready;
	assign adv        = valid_s1 && (!has_result || out_free);
	assign cmd.ready  = !valid_s1 || adv;

	// start setup
	assign dx       = DELTA_BITS'(x1_s1) - DELTA_BITS'(x0_s1);
	assign dy       = DELTA_BITS'(y1_s1) - DELTA_BITS'(y0_s1);
	assign adx_new  = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
	assign ady_new  = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
	assign err_init = (adx_new > ady_new) ? ERR_BITS'(adx_new >> 1) :
		-ERR_BITS'(ady_new >> 1);

	// pixel step
	assign adx_e    = ERR_BITS'(adx_q);
	assign ady_e    = ERR_BITS'(ady_q);
	assign move_x   = err_q > -adx_e;
	assign move_y   = err_q < ady_e;
	assign err_next = err_q - (move_x ? ady_e : '0) + (move_y ? adx_e : '0);
	assign fin      = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
	assign inb      = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
		(CMP_BITS'(unsigned'(cur_x_q)) < CMP_BITS'(cfg.width)) &&
		(CMP_BITS'(unsigned'(cur_y_q)) < CMP_BITS'(cfg.height));
	assign off_full = PROD_BITS'(unsigned'(cur_y_q)) * PROD_BITS'(cfg.width) +
		PROD_BITS'(unsigned'(cur_x_q));
	assign off      = inb ? off_full[OFFSET_BITS-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= cmd.op;
			x0_s1    <= cmd.x_start;
			y0_s1    <= cmd.y_start;
			x1_s1    <= cmd.x_end;
			y1_s1    <= cmd.y_end;
			color_s1 <= cmd.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			if (op_s1 == OP_START) begin
				busy_q <= 1'b1;
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (op_s1 == OP_START) begin
				cur_x_q      <= x0_s1;
				cur_y_q      <= y0_s1;
				goal_x_q     <= x1_s1;
				goal_y_q     <= y1_s1;
				adx_q        <= adx_new;
				ady_q        <= ady_new;
				step_x_neg_q <= dx[DELTA_BITS-1];
				step_y_neg_q <= dy[DELTA_BITS-1];
				err_q        <= err_init;
				line_color_q <= color_s1;
			end else if (busy_q && !fin) begin
				err_q <= err_next;
				if (move_x) begin
					cur_x_q <= cur_x_q + (step_x_neg_q ? '1 : COORD_BITS'(1));
				end
				if (move_y) begin
					cur_y_q <= cur_y_q + (step_y_neg_q ? '1 : COORD_BITS'(1));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			pix_x_s2  <= cur_x_q;
			pix_y_s2  <= cur_y_q;
			offset_s2 <= off;
			color_s2  <= line_color_q;
			inb_s2    <= inb;
			last_s2   <= fin;
		end
	end

	assign pix.valid        = valid_s2;
	assign pix.pix_x        = pix_x_s2;
	assign pix.pix_y        = pix_y_s2;
	assign pix.pixel_offset = offset_s2;
	assign pix.pix_color    = color_s2;
	assign pix.in_bounds    = inb_s2;
	assign pix.last         = last_s2;

`ifndef NO_ASSERTIONS
	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == OP_START) |=> busy_q)
		else $error("start did not activate line");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && has_result && fin) |=> (!busy_q && valid_s2 && last_s2))
		else $error("endpoint pixel did not end the line");

	a_offset_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !inb_s2) |-> (offset_s2 == '0))
		else $error("offset given for clipped pixel");

	a_unit_step_x: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && has_result && !fin) |=> (cur_x_q == $past(cur_x_q) ||
			cur_x_q == $past(cur_x_q) + COORD_BITS'(1) ||
			cur_x_q == $past(cur_x_q) - COORD_BITS'(1)))
		else $error("column moved by more than one");
`endif

endmodule

`default_nettype wire
